[rtl/utfsv_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 source validator package
// Shared widths, fault codes and the result record passed to the top level.
// ----------------------------------------------------------------------------
package utfsv_pkg;

    // Counter widths
    localparam int OFFSET_BITS     = 32;
    localparam int LINE_COUNT_BITS = 32;

    // Reported field widths
    localparam int KIND_W     = 4;
    localparam int OUT_OFF_W  = 32;
    localparam int OUT_LINE_W = 32;
    localparam int OUT_DATA_W = 72;  // 70 payload bits padded to bytes

    typedef logic [KIND_W-1:0]          t_kind;
    typedef logic [OFFSET_BITS-1:0]     t_pos;
    typedef logic [LINE_COUNT_BITS-1:0] t_tally;

    // Fault kinds
    localparam t_kind K_NONE     = 4'd0;
    localparam t_kind K_STRAY    = 4'd1;
    localparam t_kind K_OVERLONG = 4'd2;
    localparam t_kind K_RANGE    = 4'd3;
    localparam t_kind K_BADLEAD  = 4'd4;
    localparam t_kind K_TRUNC    = 4'd5;
    localparam t_kind K_BADCONT  = 4'd6;
    localparam t_kind K_SURR     = 4'd7;
    localparam t_kind K_LARGE    = 4'd8;

    // Byte-order mark progress: MARK_DONE ends the search
    localparam logic [1:0] MARK_DONE = 2'd3;

    // Byte values used by the rules
    localparam logic [7:0] B_NEWLINE = 8'h0A;
    localparam logic [7:0] B_BOM0    = 8'hEF;
    localparam logic [7:0] B_BOM1    = 8'hBB;
    localparam logic [7:0] B_BOM2    = 8'hBF;
    localparam logic [7:0] B_E0      = 8'hE0;
    localparam logic [7:0] B_ED      = 8'hED;
    localparam logic [7:0] B_F0      = 8'hF0;
    localparam logic [7:0] B_F4      = 8'hF4;

    // Result record
    typedef struct packed {
        logic                  source_ok;
        t_kind                 error_kind;
        logic [OUT_OFF_W-1:0]  error_offset;
        logic [OUT_LINE_W-1:0] line_total;
        logic                  has_bom;
    } t_result;

endpackage

[rtl/utfsv_core.sv]
// ----------------------------------------------------------------------------
// UTF-8 source validator core
// Decoder state registers and the per-byte rule logic; one byte per step.
// ----------------------------------------------------------------------------
module utfsv_core
    import utfsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,      // registered item is consumed this cycle
    input  logic [7:0] i_byte,
    input  logic       i_present,
    input  logic       i_last,
    output t_result    o_result     // valid when i_step and i_last
);

    localparam t_tally TALLY_MAX = '1;

    // State
    t_pos       r_pos, n_pos;
    logic [1:0] r_exp, n_exp;
    logic [2:0] r_width, n_width;
    logic [7:0] r_lead, n_lead;
    t_pos       r_lead_pos, n_lead_pos;
    t_kind      r_held_kind, n_held_kind;
    t_pos       r_held_pos, n_held_pos;
    logic       r_fault_final, n_fault_final;
    t_tally     r_tally, n_tally;
    logic [1:0] r_mark_stage, n_mark_stage;
    logic       r_mark_seen, n_mark_seen;
    logic       r_large_seen, n_large_seen;
    t_pos       r_large_pos, n_large_pos;

    // Next state and result
    always_comb begin
        logic [7:0] v_mark;
        logic       v_second;
        t_kind      v_k;
        t_kind      v_kind;
        t_pos       v_where;

        n_pos         = r_pos;
        n_exp         = r_exp;
        n_width       = r_width;
        n_lead        = r_lead;
        n_lead_pos    = r_lead_pos;
        n_held_kind   = r_held_kind;
        n_held_pos    = r_held_pos;
        n_fault_final = r_fault_final;
        n_tally       = r_tally;
        n_mark_stage  = r_mark_stage;
        n_mark_seen   = r_mark_seen;
        n_large_seen  = r_large_seen;
        n_large_pos   = r_large_pos;
        v_second      = 1'b0;
        v_k           = K_NONE;
        v_kind        = K_NONE;
        v_where       = '0;

        unique case (r_mark_stage)
            2'd0:    v_mark = B_BOM0;
            2'd1:    v_mark = B_BOM1;
            default: v_mark = B_BOM2;
        endcase

        if (i_step && i_present && !r_fault_final) begin
            n_pos = r_pos + 1'b1;

            // Byte-order mark tracking
            if (r_mark_stage != MARK_DONE) begin
                if (i_byte == v_mark) begin
                    n_mark_stage = r_mark_stage + 2'd1;
                    if (r_mark_stage == 2'd2) n_mark_seen = 1'b1;
                end else begin
                    n_mark_stage = MARK_DONE;
                end
            end

            // Line counting, first overflow remembered
            if (i_byte == B_NEWLINE) begin
                if (r_tally == TALLY_MAX) begin
                    if (!r_large_seen) begin
                        n_large_seen = 1'b1;
                        n_large_pos  = r_pos;
                    end
                end else begin
                    n_tally = r_tally + 1'b1;
                end
            end

            if (r_exp == 2'd0) begin
                // Lead byte classification
                priority if (i_byte <= 8'h7F) begin
                end else if (i_byte <= 8'hBF) begin
                    n_held_kind = K_STRAY; n_held_pos = r_pos; n_fault_final = 1'b1;
                end else if (i_byte <= 8'hC1) begin
                    n_held_kind = K_OVERLONG; n_held_pos = r_pos; n_fault_final = 1'b1;
                end else if (i_byte >= 8'hF8) begin
                    n_held_kind = K_BADLEAD; n_held_pos = r_pos; n_fault_final = 1'b1;
                end else if (i_byte >= 8'hF5) begin
                    n_held_kind = K_RANGE; n_held_pos = r_pos; n_fault_final = 1'b1;
                end else begin
                    if (i_byte <= 8'hDF) begin
                        n_width = 3'd2;
                        n_exp   = 2'd1;
                    end else if (i_byte <= 8'hEF) begin
                        n_width = 3'd3;
                        n_exp   = 2'd2;
                    end else begin
                        n_width = 3'd4;
                        n_exp   = 2'd3;
                    end
                    n_lead     = i_byte;
                    n_lead_pos = r_pos;
                end
            end else begin
                // Continuation byte; fault held until the sequence completes
                if (r_held_kind == K_NONE) begin
                    v_second = (r_width - {1'b0, r_exp}) == 3'd1;
                    priority if (i_byte < 8'h80 || i_byte > 8'hBF) v_k = K_BADCONT;
                    else if (v_second && r_lead == B_E0 && i_byte < 8'hA0) v_k = K_OVERLONG;
                    else if (v_second && r_lead == B_ED && i_byte >= 8'hA0) v_k = K_SURR;
                    else if (v_second && r_lead == B_F0 && i_byte < 8'h90) v_k = K_OVERLONG;
                    else if (v_second && r_lead == B_F4 && i_byte > 8'h8F) v_k = K_RANGE;
                    else v_k = K_NONE;
                    if (v_k != K_NONE) begin
                        n_held_kind = v_k;
                        n_held_pos  = r_pos;
                    end
                end
                n_exp = r_exp - 2'd1;
                if (r_exp == 2'd1 && n_held_kind != K_NONE) n_fault_final = 1'b1;
            end
        end

        // Close of source: report from post-byte state
        priority if (n_fault_final) begin
            v_kind  = n_held_kind;
            v_where = n_held_pos;
        end else if (n_exp != 2'd0) begin
            v_kind  = K_TRUNC;
            v_where = n_lead_pos;
        end else if (n_large_seen) begin
            v_kind  = K_LARGE;
            v_where = n_large_pos;
        end else begin
            v_kind  = K_NONE;
            v_where = '0;
        end

        o_result.source_ok    = (v_kind == K_NONE);
        o_result.error_kind   = v_kind;
        o_result.error_offset = OUT_OFF_W'(v_where);
        o_result.line_total   = (v_kind == K_NONE) ? OUT_LINE_W'(n_tally) : '0;
        o_result.has_bom      = (v_kind == K_NONE) && n_mark_seen;

        // Back to the reset state for the next source
        if (i_step && i_last) begin
            n_pos         = '0;
            n_exp         = 2'd0;
            n_width       = 3'd0;
            n_lead        = 8'd0;
            n_lead_pos    = '0;
            n_held_kind   = K_NONE;
            n_held_pos    = '0;
            n_fault_final = 1'b0;
            n_tally       = t_tally'(1);
            n_mark_stage  = 2'd0;
            n_mark_seen   = 1'b0;
            n_large_seen  = 1'b0;
            n_large_pos   = '0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_exp         <= 2'd0;
            r_width       <= 3'd0;
            r_lead        <= 8'd0;
            r_lead_pos    <= '0;
            r_held_kind   <= K_NONE;
            r_held_pos    <= '0;
            r_fault_final <= 1'b0;
            r_tally       <= t_tally'(1);
            r_mark_stage  <= 2'd0;
            r_mark_seen   <= 1'b0;
            r_large_seen  <= 1'b0;
            r_large_pos   <= '0;
        end else begin
            r_pos         <= n_pos;
            r_exp         <= n_exp;
            r_width       <= n_width;
            r_lead        <= n_lead;
            r_lead_pos    <= n_lead_pos;
            r_held_kind   <= n_held_kind;
            r_held_pos    <= n_held_pos;
            r_fault_final <= n_fault_final;
            r_tally       <= n_tally;
            r_mark_stage  <= n_mark_stage;
            r_mark_seen   <= n_mark_seen;
            r_large_seen  <= n_large_seen;
            r_large_pos   <= n_large_pos;
        end
    end

    // Checks
    a_final_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault_final |-> (r_held_kind != K_NONE))
        else $error("final fault without a kind");

    a_exp_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != 2'd0) |-> ({1'b0, r_exp} < r_width))
        else $error("pending count exceeds sequence width");

    a_mark_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark_seen |-> (r_mark_stage == MARK_DONE))
        else $error("mark seen before match finished");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_pos == '0 && r_exp == 2'd0 && !r_fault_final))
        else $error("state not cleared after source close");

    a_ok_no_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.source_ok |-> (o_result.error_kind == K_NONE && !r_fault_final))
        else $error("ok result with a fault");

endmodule

[rtl/utf8_source_validator.sv]
// ----------------------------------------------------------------------------
// UTF-8 source validator
// Streams one source byte per cycle save stalled closing items, and reports
// the first fault, line count and byte-order mark on the item marked last.
//
//  channel | dir | tdata                       | tuser        | tlast
//  s_axis  | in  | [7:0] data_byte             | byte_present | last_item
//  m_axis  | out | see port comment            | -            | -
//
// One byte per cycle sustained but for stalled closing items: input register,
// rule logic, result register; a closing item's step registers its result.
// Reset is synchronous, active low; the decoder returns to its start state.
// A stalled result holds the input stage only when the stage holds a closing
// item; other items keep flowing.
// ----------------------------------------------------------------------------
module utf8_source_validator
    import utfsv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
    input  logic                  s_axis_tuser,  // [0] byte_present
    input  logic                  s_axis_tlast,  // last_item
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] source_ok, [4:1] error_kind, [36:5] error_offset,
    // [68:37] line_total, [69] has_bom, [71:70] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_present;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_out_free;
    logic       w_adv;

    // Handshake: closing items wait for a free result slot
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte    <= s_axis_tdata;
            r_in_present <= s_axis_tuser;
            r_in_last    <= s_axis_tlast;
        end
    end

    // Decoder
    utfsv_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_byte    (r_in_byte),
        .i_present (r_in_present),
        .i_last    (r_in_last),
        .o_result  (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) r_out <= w_result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.has_bom, r_out.line_total, r_out.error_offset,
                            r_out.error_kind, r_out.source_ok};

endmodule

[bench/tb_utf8_source_validator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for utf8_source_validator
// Sends source texts byte by byte: a short directed set first, covering each
// fault kind but K_LARGE, the byte-order mark and empty sources, then
// random texts, most well-formed UTF-8, some corrupted, truncated or pure noise.
// A predictor follows every accepted request and queues the report due on each
// closing request; the monitor checks each report field against the oldest
// one. Both sides idle in random bursts, except in quiet stretches and near
// the end.
// ----------------------------------------------------------------------------
module tb_utf8_source_validator;
    import utfsv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1875;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } text_item_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic                  s_axis_tuser = 1'b0;    // [0] byte_present
    logic                  s_axis_tlast = 1'b0;    // last_item
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] source_ok, [4:1] error_kind, [36:5] error_offset,
    // [68:37] line_total, [69] has_bom, [71:70] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    utf8_source_validator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Stimulus and expected reports
    text_item_t pending_bytes[$];
    logic [7:0] text_q[$];
    t_result    expected_reports[$];
    int         items_total = 0;
    int         accepted_cnt = 0;
    int         fail_count = 0;
    int         cycle_cnt = 0;
    int         src_gap = 0;
    int         snk_gap = 0;
    logic       late_phase = 1'b0;

    // Predictor state
    t_pos       pos_cnt;
    logic [1:0] cont_left;
    logic [2:0] seq_len;
    logic [7:0] lead_byte;
    t_pos       lead_pos;
    t_kind      fault_kind;
    t_pos       fault_pos;
    logic       fault_locked;
    t_tally     line_cnt;
    logic [1:0] bom_stage;
    logic       bom_found;
    logic       big_seen;
    t_pos       big_pos;

    function void reset_decoder();
        pos_cnt      = '0;
        cont_left    = '0;
        seq_len      = '0;
        lead_byte    = '0;
        lead_pos     = '0;
        fault_kind   = K_NONE;
        fault_pos    = '0;
        fault_locked = 1'b0;
        line_cnt     = t_tally'(1);
        bom_stage    = '0;
        bom_found    = 1'b0;
        big_seen     = 1'b0;
        big_pos      = '0;
    endfunction

    // One source byte through the decoder
    function void scan_byte(input logic [7:0] b);
        t_pos       at;
        logic [7:0] bom_want;
        logic       second;
        t_kind      k;
        at = pos_cnt;
        pos_cnt = pos_cnt + 1'b1;

        // byte-order mark tracking
        if (bom_stage != MARK_DONE) begin
            case (bom_stage)
                2'd0:    bom_want = B_BOM0;
                2'd1:    bom_want = B_BOM1;
                default: bom_want = B_BOM2;
            endcase
            if (b == bom_want) begin
                bom_stage = bom_stage + 1'b1;
                if (bom_stage == MARK_DONE) bom_found = 1'b1;
            end else begin
                bom_stage = MARK_DONE;
            end
        end

        // line counting, saturating
        if (b == B_NEWLINE) begin
            if (line_cnt == '1) begin
                if (!big_seen) begin
                    big_seen = 1'b1;
                    big_pos  = at;
                end
            end else begin
                line_cnt = line_cnt + 1'b1;
            end
        end

        if (cont_left == 0) begin
            // lead byte
            if (b <= 8'h7F) begin
            end else if (b <= 8'hBF) begin
                fault_kind = K_STRAY; fault_pos = at; fault_locked = 1'b1;
            end else if (b <= 8'hC1) begin
                fault_kind = K_OVERLONG; fault_pos = at; fault_locked = 1'b1;
            end else if (b >= 8'hF5 && b <= 8'hF7) begin
                fault_kind = K_RANGE; fault_pos = at; fault_locked = 1'b1;
            end else if (b >= 8'hF8) begin
                fault_kind = K_BADLEAD; fault_pos = at; fault_locked = 1'b1;
            end else begin
                seq_len   = (b <= 8'hDF) ? 3'd2 : (b <= 8'hEF) ? 3'd3 : 3'd4;
                cont_left = 2'(seq_len - 3'd1);
                lead_byte = b;
                lead_pos  = at;
            end
        end else begin
            // continuation byte; a fault here waits for the sequence end
            if (fault_kind == K_NONE) begin
                second = (int'(seq_len) - int'(cont_left)) == 1;
                k = K_NONE;
                if (b < 8'h80 || b > 8'hBF) k = K_BADCONT;
                else if (second && lead_byte == B_E0 && b < 8'hA0) k = K_OVERLONG;
                else if (second && lead_byte == B_ED && b >= 8'hA0) k = K_SURR;
                else if (second && lead_byte == B_F0 && b < 8'h90) k = K_OVERLONG;
                else if (second && lead_byte == B_F4 && b > 8'h8F) k = K_RANGE;
                if (k != K_NONE) begin
                    fault_kind = k;
                    fault_pos  = at;
                end
            end
            cont_left = cont_left - 1'b1;
            if (cont_left == 0 && fault_kind != K_NONE) fault_locked = 1'b1;
        end
    endfunction

    // Report due on a closing request
    function void close_source();
        t_result r;
        t_kind   k;
        t_pos    where;
        k = K_NONE;
        where = '0;
        if (fault_locked) begin
            k = fault_kind;
            where = fault_pos;
        end else if (cont_left != 0) begin
            k = K_TRUNC;
            where = lead_pos;
        end else if (big_seen) begin
            k = K_LARGE;
            where = big_pos;
        end
        r.source_ok    = (k == K_NONE);
        r.error_kind   = k;
        r.error_offset = OUT_OFF_W'(where);
        r.line_total   = (k == K_NONE) ? OUT_LINE_W'(line_cnt) : '0;
        r.has_bom      = (k == K_NONE) && bom_found;
        expected_reports.push_back(r);
        reset_decoder();
    endfunction

    // Move the staged text into the request queue
    function void flush_text(input bit empty_close, input bit with_gaps);
        for (int i = 0; i < text_q.size(); i++) begin
            if (with_gaps && $urandom_range(0, 11) == 0)
                pending_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
            pending_bytes.push_back('{text_q[i], 1'b1,
                                      !empty_close && i == text_q.size() - 1});
        end
        if (empty_close)
            pending_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
        text_q.delete();
    endfunction

    function void check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
            fail_count++;
        end
    endfunction

    // Driver: feeds requests, predicts on each acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser && !fault_locked) scan_byte(s_axis_tdata);
                if (s_axis_tlast) close_source();
                accepted_cnt++;
            end
            late_phase <= (pending_bytes.size() < 120);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (!late_phase && (cycle_cnt % 600) < 450
                             && $urandom_range(0, 6) == 0) begin
                    src_gap = $urandom_range(0, 3);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes[0].data;
                    s_axis_tuser  <= pending_bytes[0].present;
                    s_axis_tlast  <= pending_bytes[0].last;
                    void'(pending_bytes.pop_front());
                end
            end
        end
    end

    // Monitor: stalls at random, checks each report
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: report with none expected, expected none, actual %0h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    check_field("source_ok", 32'(expected_reports[0].source_ok),
                                32'(m_axis_tdata[0]));
                    check_field("error_kind", 32'(expected_reports[0].error_kind),
                                32'(m_axis_tdata[4:1]));
                    check_field("error_offset", expected_reports[0].error_offset,
                                m_axis_tdata[36:5]);
                    check_field("line_total", expected_reports[0].line_total,
                                m_axis_tdata[68:37]);
                    check_field("has_bom", 32'(expected_reports[0].has_bom),
                                32'(m_axis_tdata[69]));
                    void'(expected_reports.pop_front());
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if (!late_phase && (cycle_cnt % 600) >= 150
                         && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("utf8_source_validator verification failed");
            $finish;
        end
    end

    initial begin
        int         mode;
        int         nchars;
        int         kind;
        int         spot;
        logic [7:0] lead;
        logic [7:0] b2;
        reset_decoder();

        // Directed texts
        flush_text(1'b1, 1'b0);                                   // empty source
        text_q = {B_NEWLINE, 8'h00, 8'h7F};        flush_text(1'b0, 1'b0);
        text_q = {B_BOM0, B_BOM1, B_BOM2, B_NEWLINE}; flush_text(1'b0, 1'b0);
        text_q = {8'h80, 8'hFF};                   flush_text(1'b0, 1'b0); // stray, rest ignored
        text_q = {8'hC0};                          flush_text(1'b0, 1'b0); // overlong lead
        text_q = {8'hF5};                          flush_text(1'b0, 1'b0); // out of range lead
        text_q = {8'hF8};                          flush_text(1'b0, 1'b0); // bad lead
        text_q = {8'hE2, 8'h82};                   flush_text(1'b1, 1'b0); // truncated
        text_q = {8'hC2, 8'h41};                   flush_text(1'b0, 1'b0); // bad continuation
        text_q = {B_ED, 8'hA0, 8'h80};             flush_text(1'b0, 1'b0); // surrogate
        text_q = {B_E0, 8'h80, 8'h80};             flush_text(1'b0, 1'b0); // overlong 3-byte
        // held range fault, then the source ends inside the sequence
        pending_bytes.push_back('{B_F4, 1'b1, 1'b0});
        pending_bytes.push_back('{8'h90, 1'b1, 1'b0});
        pending_bytes.push_back('{8'h5A, 1'b0, 1'b0});
        pending_bytes.push_back('{8'hA5, 1'b0, 1'b1});

        // Random texts
        while (pending_bytes.size() < ITEM_TARGET) begin
            mode = $urandom_range(0, 9);
            if (mode == 7) begin
                // pure noise
                nchars = $urandom_range(1, 8);
                for (int i = 0; i < nchars; i++) text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    text_q.push_back(B_BOM0);
                    text_q.push_back(B_BOM1);
                    if ($urandom_range(0, 7) != 0) text_q.push_back(B_BOM2);
                end
                nchars = $urandom_range(0, 10);
                for (int i = 0; i < nchars; i++) begin
                    kind = $urandom_range(0, mode == 6 ? 8 : 7);
                    case (kind)
                        0, 1, 2, 3: text_q.push_back(8'($urandom_range(0, 127)));
                        4: text_q.push_back(B_NEWLINE);
                        5: begin
                            text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        6: begin
                            lead = 8'($urandom_range(8'hE0, 8'hEF));
                            if (lead == B_E0)      b2 = 8'($urandom_range(8'hA0, 8'hBF));
                            else if (lead == B_ED) b2 = 8'($urandom_range(8'h80, 8'h9F));
                            else                   b2 = 8'($urandom_range(8'h80, 8'hBF));
                            text_q.push_back(lead);
                            text_q.push_back(b2);
                            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        7: begin
                            lead = 8'($urandom_range(8'hF0, 8'hF4));
                            if (lead == B_F0)      b2 = 8'($urandom_range(8'h90, 8'hBF));
                            else if (lead == B_F4) b2 = 8'($urandom_range(8'h80, 8'h8F));
                            else                   b2 = 8'($urandom_range(8'h80, 8'hBF));
                            text_q.push_back(lead);
                            text_q.push_back(b2);
                            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        default: begin
                            // special leads with any continuation as second byte
                            case ($urandom_range(0, 3))
                                0:       lead = B_E0;
                                1:       lead = B_ED;
                                2:       lead = B_F0;
                                default: lead = B_F4;
                            endcase
                            text_q.push_back(lead);
                            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                            if (lead >= B_F0)
                                text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                    endcase
                end
                if (mode == 8 && text_q.size() > 0) begin
                    spot = $urandom_range(0, text_q.size() - 1);
                    text_q[spot] = 8'($urandom_range(0, 255));
                end
                if (mode == 9) begin
                    // end inside a sequence
                    lead = 8'($urandom_range(8'hC2, 8'hF4));
                    text_q.push_back(lead);
                    if (lead >= B_E0 && $urandom_range(0, 1) == 1)
                        text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
            end
            flush_text(text_q.size() == 0 || $urandom_range(0, 3) == 0, 1'b1);
        end
        items_total = pending_bytes.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < items_total || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("utf8_source_validator verification clean");
        end else begin
            $display("utf8_source_validator verification failed");
        end
        $finish;
    end

endmodule

[utf8_source_validator.f]
rtl/utfsv_pkg.sv
rtl/utfsv_core.sv
rtl/utf8_source_validator.sv
bench/tb_utf8_source_validator.sv
